/* hw/rtl/i2crtm_pkg.sv */
// Shared types and constants of the I2C register transaction master.
// Request and result records, phase codes, status and register indexes.
// No dependencies.
package i2crtm_pkg;

  localparam int unsigned MaxBytesDef = 32;

  localparam logic [6:0]  SlaveAddrRst  = 7'd16;
  localparam logic [15:0] AckTimeoutRst = 16'd100;

  // configuration register indexes
  localparam logic [1:0] CfgSlaveAddr  = 2'd0;
  localparam logic [1:0] CfgAckTimeout = 2'd1;

  // byte positions within a transaction
  localparam int unsigned PosAddrWr = 0;
  localparam int unsigned PosRegHi  = 1;
  localparam int unsigned PosRegLo  = 2;
  localparam int unsigned PosLen    = 3;
  localparam int unsigned PosAddrRw = 4;
  localparam int unsigned PosData   = 5;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_LOAD  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NACK   = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [17:0] {
    PH_IDLE      = 18'h00001,
    PH_START_A   = 18'h00002,
    PH_START_B   = 18'h00004,
    PH_START_C   = 18'h00008,
    PH_TX_LOW    = 18'h00010,
    PH_TX_HIGH   = 18'h00020,
    PH_ACK_REL   = 18'h00040,
    PH_ACK_HIGH  = 18'h00080,
    PH_ACK_POLL  = 18'h00100,
    PH_RX_REL    = 18'h00200,
    PH_RX_HIGH   = 18'h00400,
    PH_RX_LOW    = 18'h00800,
    PH_MACK_SET  = 18'h01000,
    PH_MACK_HIGH = 18'h02000,
    PH_MACK_LOW  = 18'h04000,
    PH_STOP_A    = 18'h08000,
    PH_STOP_B    = 18'h10000,
    PH_STOP_C    = 18'h20000
  } phase_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        sda_in;
    logic        is_read;
    logic [15:0] reg_address;
    logic [5:0]  byte_count;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage

/* hw/rtl/i2crtm_if.sv */
// Valid/ready channel interfaces of the I2C register transaction master.
// One for requests, one for results; no dependencies.
interface i2crtm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        sda_in;
  logic        is_read;
  logic [15:0] reg_address;
  logic [5:0]  byte_count;
  logic [7:0]  write_byte;

  modport source (output valid, req_type, sda_in, is_read, reg_address, byte_count,
                  write_byte, input ready);
  modport sink (input valid, req_type, sda_in, is_read, reg_address, byte_count,
                write_byte, output ready);
endinterface

interface i2crtm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       read_last;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, scl_level, sda_level, read_byte, read_valid, read_last,
                  busy_res, done_res, status, input ready);
  modport sink (input valid, scl_level, sda_level, read_byte, read_valid, read_last,
                busy_res, done_res, status, output ready);
endinterface

/* hw/rtl/i2crtm_core.sv */
// Bus phase engine: transaction state, write buffer and configuration registers.
// Computes one result per request combinationally; uses i2crtm_pkg.
module i2crtm_core import i2crtm_pkg::*; #(
  parameter int unsigned MaxBytes = MaxBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        step_i,
  input  req_t        req_i,
  output res_t        res_o
);

  localparam int unsigned AddrW    = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;
  localparam int unsigned FillW    = $clog2(MaxBytes + 1);
  localparam int unsigned ByteIdxW = $clog2(MaxBytes + 6);
  localparam int unsigned CmpW     = ((ByteIdxW > 6) ? ByteIdxW : 6) + 1;

  phase_e               phase_q, phase_d;
  logic [2:0]           bit_q, bit_d;
  logic [ByteIdxW-1:0]  bidx_q, bidx_d;
  logic [7:0]           shift_q, shift_d;
  logic [16:0]          poll_q, poll_d;
  logic [FillW-1:0]     fill_q, fill_d;
  logic                 rd_q, rd_d;
  logic [15:0]          regaddr_q, regaddr_d;
  logic [5:0]           cnt_q, cnt_d;
  logic [1:0]           lines_q, lines_d;
  logic [6:0]           saddr_q;
  logic [15:0]          tout_q;

  logic [7:0]           mem [MaxBytes];
  logic [7:0]           rdata_q;
  logic [AddrW-1:0]     rd_addr;
  logic                 load_we;

  logic                 busy;
  logic [CmpW-1:0]      cnt_w, bidx_w;
  logic                 last_rx;
  logic [7:0]           tx_byte, cur_byte, rx_shift;
  logic [16:0]          poll_inc;
  logic                 reject;

  assign busy    = (phase_q != PH_IDLE);
  assign cnt_w   = CmpW'(cnt_q);
  assign bidx_w  = CmpW'(bidx_q);
  assign last_rx = ((bidx_w + CmpW'(1)) >= cnt_w);
  assign rx_shift = {shift_q[6:0], req_i.sda_in};
  assign poll_inc = poll_q + 17'd1;
  assign cur_byte = (bit_q == 3'd0) ? tx_byte : shift_q;
  assign reject  = (req_i.is_read && (req_i.byte_count == 6'd0)) ||
                   (CmpW'(req_i.byte_count) > CmpW'(MaxBytes)) ||
                   (!req_i.is_read && (CmpW'(req_i.byte_count) > CmpW'(fill_q)));

  always_comb begin
    case (bidx_q)
      ByteIdxW'(PosAddrWr): tx_byte = {saddr_q, 1'b0};
      ByteIdxW'(PosRegHi):  tx_byte = regaddr_q[15:8];
      ByteIdxW'(PosRegLo):  tx_byte = regaddr_q[7:0];
      ByteIdxW'(PosLen):    tx_byte = {2'b00, cnt_q};
      ByteIdxW'(PosAddrRw): tx_byte = {saddr_q, rd_q};
      default:              tx_byte = rdata_q;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    bit_d     = bit_q;
    bidx_d    = bidx_q;
    shift_d   = shift_q;
    poll_d    = poll_q;
    fill_d    = fill_q;
    rd_d      = rd_q;
    regaddr_d = regaddr_q;
    cnt_d     = cnt_q;
    lines_d   = lines_q;
    load_we   = 1'b0;
    res_o     = '0;
    if (step_i) begin
      case (req_i.req_type)
        REQ_START: begin
          if (!busy) begin
            if (reject) begin
              res_o.done_res = 1'b1;
              res_o.status   = ST_REJECT;
            end else begin
              rd_d      = req_i.is_read;
              regaddr_d = req_i.reg_address;
              cnt_d     = req_i.byte_count;
              fill_d    = '0;
              bit_d     = 3'd0;
              bidx_d    = '0;
              shift_d   = 8'd0;
              poll_d    = 17'd0;
              phase_d   = PH_START_A;
            end
          end
        end
        REQ_LOAD: begin
          if (!busy && (fill_q < FillW'(MaxBytes))) begin
            load_we = 1'b1;
            fill_d  = fill_q + FillW'(1);
          end
        end
        REQ_TICK: begin
          case (phase_q)
            PH_START_A: begin
              lines_d = 2'b11;
              phase_d = PH_START_B;
            end
            PH_START_B: begin
              lines_d = 2'b10;
              phase_d = PH_START_C;
            end
            PH_START_C: begin
              lines_d = 2'b00;
              bit_d   = 3'd0;
              phase_d = PH_TX_LOW;
            end
            PH_TX_LOW: begin
              shift_d = cur_byte;
              lines_d = {1'b0, cur_byte[3'd7 - bit_q]};
              phase_d = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
              lines_d = {1'b1, lines_q[0]};
              if (bit_q == 3'd7) begin
                bit_d   = 3'd0;
                phase_d = PH_ACK_REL;
              end else begin
                bit_d   = bit_q + 3'd1;
                phase_d = PH_TX_LOW;
              end
            end
            PH_ACK_REL: begin
              lines_d = 2'b01;
              poll_d  = 17'd0;
              phase_d = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
              lines_d = 2'b11;
              phase_d = PH_ACK_POLL;
            end
            PH_ACK_POLL: begin
              if (!req_i.sda_in) begin
                lines_d = 2'b01;
                bit_d   = 3'd0;
                if (bidx_q < ByteIdxW'(PosLen)) begin
                  bidx_d  = bidx_q + ByteIdxW'(1);
                  phase_d = PH_TX_LOW;
                end else if (bidx_q == ByteIdxW'(PosLen)) begin
                  bidx_d  = ByteIdxW'(PosAddrRw);
                  phase_d = PH_START_A;
                end else if (bidx_q == ByteIdxW'(PosAddrRw)) begin
                  if (rd_q) begin
                    bidx_d  = '0;
                    phase_d = PH_RX_REL;
                  end else if (cnt_q == 6'd0) begin
                    bit_d   = {1'b0, ST_OK};
                    phase_d = PH_STOP_A;
                  end else begin
                    bidx_d  = ByteIdxW'(PosData);
                    phase_d = PH_TX_LOW;
                  end
                end else if ((bidx_w - CmpW'(PosAddrRw)) >= cnt_w) begin
                  bit_d   = {1'b0, ST_OK};
                  phase_d = PH_STOP_A;
                end else begin
                  bidx_d  = bidx_q + ByteIdxW'(1);
                  phase_d = PH_TX_LOW;
                end
              end else begin
                poll_d = poll_inc;
                if (poll_inc >= (17'(tout_q) + 17'd2)) begin
                  lines_d = 2'b01;
                  bit_d   = {1'b0, ST_NACK};
                  phase_d = PH_STOP_A;
                end else begin
                  lines_d = 2'b11;
                end
              end
            end
            PH_RX_REL: begin
              lines_d = 2'b01;
              bit_d   = 3'd0;
              shift_d = 8'd0;
              phase_d = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
              lines_d = 2'b11;
              phase_d = PH_RX_LOW;
            end
            PH_RX_LOW: begin
              lines_d = 2'b01;
              shift_d = rx_shift;
              if (bit_q == 3'd7) begin
                bit_d            = 3'd0;
                res_o.read_valid = 1'b1;
                res_o.read_byte  = rx_shift;
                res_o.read_last  = last_rx;
                phase_d          = PH_MACK_SET;
              end else begin
                bit_d   = bit_q + 3'd1;
                phase_d = PH_RX_HIGH;
              end
            end
            PH_MACK_SET: begin
              lines_d = {1'b0, last_rx};
              phase_d = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
              lines_d = {1'b1, lines_q[0]};
              phase_d = PH_MACK_LOW;
            end
            PH_MACK_LOW: begin
              lines_d = {1'b0, lines_q[0]};
              if (last_rx) begin
                bit_d   = {1'b0, ST_OK};
                phase_d = PH_STOP_A;
              end else begin
                bidx_d  = bidx_q + ByteIdxW'(1);
                phase_d = PH_RX_REL;
              end
            end
            PH_STOP_A: begin
              lines_d = 2'b00;
              phase_d = PH_STOP_B;
            end
            PH_STOP_B: begin
              lines_d = 2'b10;
              phase_d = PH_STOP_C;
            end
            PH_STOP_C: begin
              lines_d        = 2'b11;
              res_o.done_res = 1'b1;
              res_o.status   = bit_q[1:0];
              bit_d          = 3'd0;
              bidx_d         = '0;
              phase_d        = PH_IDLE;
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    res_o.scl_level = lines_d[1];
    res_o.sda_level = lines_d[0];
    res_o.busy_res  = (phase_d != PH_IDLE);
  end

  assign rd_addr = AddrW'(bidx_d - ByteIdxW'(PosData));

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem[fill_q[AddrW-1:0]] <= req_i.write_byte;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_q     <= 3'd0;
      bidx_q    <= '0;
      shift_q   <= 8'd0;
      poll_q    <= 17'd0;
      fill_q    <= '0;
      rd_q      <= 1'b0;
      regaddr_q <= 16'd0;
      cnt_q     <= 6'd0;
      lines_q   <= 2'b11;
      saddr_q   <= SlaveAddrRst;
      tout_q    <= AckTimeoutRst;
    end else begin
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      bidx_q    <= bidx_d;
      shift_q   <= shift_d;
      poll_q    <= poll_d;
      fill_q    <= fill_d;
      rd_q      <= rd_d;
      regaddr_q <= regaddr_d;
      cnt_q     <= cnt_d;
      lines_q   <= lines_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgSlaveAddr:  saddr_q <= cfg_wdata_i[6:0];
          CfgAckTimeout: tout_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* hw/rtl/i2c_register_transaction_master.sv */
// I2C register transaction master, top level; uses i2crtm_pkg, i2crtm_if, i2crtm_core.
// Each request passes through a request register, the phase logic and a result register.
// Throughput: 1 request per cycle while results are taken; phase logic is combinational.
// Reset: phase idle, lines high, slave address 16, ack timeout 100; buffer unreset.
module i2c_register_transaction_master import i2crtm_pkg::*; #(
  parameter int unsigned MaxBytes = MaxBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  i2crtm_req_if.sink         req_i,
  i2crtm_res_if.source       res_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_wdata_i
);

  req_t inq_q;
  logic inq_valid_q;
  res_t res_q, res_d;
  logic res_valid_q;
  logic fire;

  assign fire        = inq_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !inq_valid_q || fire;

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      inq_q <= '{req_type:    req_i.req_type,
                 sda_in:      req_i.sda_in,
                 is_read:     req_i.is_read,
                 reg_address: req_i.reg_address,
                 byte_count:  req_i.byte_count,
                 write_byte:  req_i.write_byte};
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        inq_valid_q <= req_i.valid;
      end
      if (fire) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  i2crtm_core #(
    .MaxBytes(MaxBytes)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (fire),
    .req_i      (inq_q),
    .res_o      (res_d)
  );

  assign res_o.valid      = res_valid_q;
  assign res_o.scl_level  = res_q.scl_level;
  assign res_o.sda_level  = res_q.sda_level;
  assign res_o.read_byte  = res_q.read_byte;
  assign res_o.read_valid = res_q.read_valid;
  assign res_o.read_last  = res_q.read_last;
  assign res_o.busy_res   = res_q.busy_res;
  assign res_o.done_res   = res_q.done_res;
  assign res_o.status     = res_q.status;

  a_done_not_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.done_res && res_q.read_valid))
    else $error("done and read byte in one result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.done_res) |-> !res_q.busy_res)
    else $error("busy after done");

  a_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.done_res) |-> (res_q.status == ST_OK))
    else $error("status without done");

  a_hold_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inq_valid_q && !fire) |=> (inq_valid_q && $stable(inq_q)))
    else $error("pending request lost");

endmodule
